### design/mdu_pkg.sv
// Package for the multiply/divide unit: word width, operation codes and the
// control bundle passed from the sequencer to the datapath. No dependencies.
`default_nettype none

package mdu_pkg;

    localparam int WORD_W  = 32;
    localparam int COUNT_W = $clog2(WORD_W);

    localparam logic [1:0] KIND_SET_DIV = 2'd0;
    localparam logic [1:0] KIND_DIVIDE  = 2'd1;
    localparam logic [1:0] KIND_MULT    = 2'd2;

    localparam logic [WORD_W-1:0] ALL_ONES = {WORD_W{1'b1}};

    typedef struct packed {
        logic load;     // an item is transferred in this cycle
        logic step;     // one iteration of the shared adder
        logic is_mul;   // iteration is a multiply step, else a divide step
        logic last;     // final iteration of the item
    } mdu_ctrl_t;

endpackage

`default_nettype wire

### design/mdu_seq.sv
// Sequencer of the multiply/divide unit: idle/run state, iteration counter
// and the result strobe. Depends on mdu_pkg.
`default_nettype none

module mdu_seq
    import mdu_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [1:0]  kind,
    input  wire logic        div_ovf,
    output logic             busy,
    output logic             done,
    output mdu_ctrl_t        ctrl
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic               state_reg, state_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               mul_reg, mul_next;
    logic               done_reg, done_next;
    logic               accept;
    logic               iterate;
    logic               last;

    assign busy    = (state_reg == ST_RUN);
    assign accept  = start && !busy;
    assign iterate = (kind == KIND_MULT) || ((kind == KIND_DIVIDE) && !div_ovf);
    assign last    = (count_reg == COUNT_W'(WORD_W - 1));

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        mul_next   = mul_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (iterate)
                    begin
                        state_next = ST_RUN;
                        count_next = '0;
                        mul_next   = (kind == KIND_MULT);
                    end
                    else
                    begin
                        done_next = 1'b1;
                    end
                end
            end
            ST_RUN:
            begin
                count_next = count_reg + 1'b1;
                if (last)
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            mul_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            mul_reg   <= mul_next;
            done_reg  <= done_next;
        end
    end

    assign done        = done_reg;
    assign ctrl.load   = accept;
    assign ctrl.step   = busy;
    assign ctrl.is_mul = mul_reg;
    assign ctrl.last   = busy && last;

endmodule

`default_nettype wire

### design/mdu_dp.sv
// Datapath of the multiply/divide unit: divisor and high-word registers,
// the shared adder/subtractor and the result register. Depends on mdu_pkg.
`default_nettype none

module mdu_dp
    import mdu_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire mdu_ctrl_t         ctrl,
    input  wire logic [1:0]        kind,
    input  wire logic [WORD_W-1:0] top_word,
    input  wire logic [WORD_W-1:0] next_word,
    output logic                   div_ovf,
    output logic [WORD_W-1:0]      result
);

    // acc_reg is the high word between items, and the running partial
    // product or remainder during an item.
    logic [WORD_W-1:0] divisor_reg;
    logic [WORD_W-1:0] acc_reg, acc_next;
    logic [WORD_W-1:0] lo_reg, lo_next;
    logic [WORD_W-1:0] mcand_reg;
    logic [WORD_W-1:0] result_reg;

    logic [WORD_W+1:0] add_a;
    logic [WORD_W+1:0] add_b;
    logic              add_cin;
    logic [WORD_W+1:0] sum;
    logic              no_borrow;

    assign div_ovf = (top_word >= divisor_reg);

    // One adder serves both operations: add for shift-add multiply,
    // subtract for restoring division.
    always_comb
    begin
        if (ctrl.is_mul)
        begin
            add_a   = {2'b00, acc_reg};
            add_b   = lo_reg[0] ? {2'b00, mcand_reg} : '0;
            add_cin = 1'b0;
        end
        else
        begin
            add_a   = {1'b0, acc_reg, lo_reg[WORD_W-1]};
            add_b   = ~{2'b00, divisor_reg};
            add_cin = 1'b1;
        end
        sum       = add_a + add_b + (WORD_W+2)'(add_cin);
        no_borrow = !sum[WORD_W+1];
    end

    always_comb
    begin
        if (ctrl.is_mul)
        begin
            acc_next = sum[WORD_W:1];
            lo_next  = {sum[0], lo_reg[WORD_W-1:1]};
        end
        else
        begin
            acc_next = no_borrow ? sum[WORD_W-1:0] : {acc_reg[WORD_W-2:0], lo_reg[WORD_W-1]};
            lo_next  = {lo_reg[WORD_W-2:0], no_borrow};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divisor_reg <= '0;
            acc_reg     <= '0;
        end
        else if (ctrl.load)
        begin
            unique case (kind)
                KIND_SET_DIV: divisor_reg <= top_word;
                KIND_DIVIDE:  acc_reg     <= div_ovf ? '0 : top_word;
                KIND_MULT:    acc_reg     <= '0;
                default:      ;
            endcase
        end
        else if (ctrl.step)
        begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            lo_reg    <= next_word;
            mcand_reg <= top_word;
            unique case (kind)
                KIND_SET_DIV: result_reg <= acc_reg;
                KIND_DIVIDE:  result_reg <= ALL_ONES;
                KIND_MULT:    result_reg <= result_reg;
                default:      result_reg <= '0;
            endcase
        end
        else if (ctrl.step)
        begin
            lo_reg <= lo_next;
            if (ctrl.last)
            begin
                result_reg <= lo_next;
            end
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

### design/mul_div_unit_with_high_word_unit.sv
// Top level of the unsigned multiply/divide unit with a high-word register.
// Instantiates mdu_seq and mdu_dp; depends on mdu_pkg.
`default_nettype none

// An item is transferred in when start is high and busy is low. Each item
// gives exactly one result, which is shown on result for a single cycle with
// done high; the receiver cannot stall it, so it must capture it then.
// Set-divisor, an overflowing divide (top word not below the divisor, which
// includes a zero divisor) and the unused code 3 do not iterate: done
// rises in the cycle after the transfer and busy stays low. Multiply and an
// in-range divide run 32 iterations of one shared 34-bit adder/subtractor,
// one bit per cycle (shift-add multiply, restoring divide), and busy is high
// during the iterations. A new item may be transferred in the same cycle
// that done is high.
module mul_div_unit_with_high_word_unit
    import mdu_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [1:0]        kind,
    input  wire logic [WORD_W-1:0] top_word,
    input  wire logic [WORD_W-1:0] next_word,
    output logic                   done,
    output logic [WORD_W-1:0]      result
);

    // Control bundle from the sequencer, and the divide overflow flag that
    // the sequencer needs to choose between the non-iterative and iterative paths.
    mdu_ctrl_t ctrl;
    logic      div_ovf;

    mdu_seq u_seq
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .kind    (kind),
        .div_ovf (div_ovf),
        .busy    (busy),
        .done    (done),
        .ctrl    (ctrl)
    );

    mdu_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .kind      (kind),
        .top_word  (top_word),
        .next_word (next_word),
        .div_ovf   (div_ovf),
        .result    (result)
    );

endmodule

`default_nettype wire
